FILE: rtl/cdd_pkg.sv
// Package for the calendar day distance block: widths, result codes and the
// constant tables of the Solar Hijri calendar. No dependencies.
package cdd_pkg;

  localparam int YEAR_WIDTH  = 12;
  localparam int DAY_W       = 5;
  localparam int MON_W       = 4;
  localparam int COUNT_W     = 21;
  localparam int ORDER_W     = 2;
  localparam int REST_W      = 6;   // year mod 33
  localparam int REST_DAYS_W = 14;  // days before a year within its cycle
  localparam int MDAY_W      = 9;   // days before the month plus day of month

  localparam int CYCLE_YEARS = 33;
  localparam int CYCLE_DAYS  = 365 * 33 + 8;

  // Year / 33 by reciprocal: estimate is low by at most one, then corrected.
  localparam int REC_SHIFT = YEAR_WIDTH + 6;
  localparam int REC_MULT  = (2 ** REC_SHIFT) / CYCLE_YEARS;
  localparam int REC_W     = REC_SHIFT - 5;
  localparam int PROD_W    = YEAR_WIDTH + REC_W;
  localparam int QUOT_W    = YEAR_WIDTH - 5;

  // Day ordinal width covers the largest year plus one cycle of margin.
  localparam int ORD_W = $clog2(((2 ** YEAR_WIDTH) / CYCLE_YEARS + 1) * CYCLE_DAYS + 1);

  localparam int IN_FIELDS_W  = 2 * (DAY_W + MON_W + YEAR_WIDTH);
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COUNT_W + ORDER_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [ORDER_W-1:0] order_t;
  localparam order_t ORDER_EQUAL   = 2'd0;
  localparam order_t ORDER_A_LATER = 2'd1;
  localparam order_t ORDER_A_EARLY = 2'd2;

  // Leap year when year mod 33 is one of eight residues.
  function automatic logic is_leap(input logic [REST_W-1:0] rest);
    logic hit;
    hit = 1'b0;
    unique case (rest)
      6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Days in the years of a cycle that come before year residue rest.
  function automatic logic [REST_DAYS_W-1:0] days_before_year(input logic [REST_W-1:0] rest);
    logic [REST_DAYS_W-1:0] acc;
    logic [REST_W-1:0]      r;
    acc = REST_DAYS_W'(rest) * REST_DAYS_W'(365);
    for (int i = 0; i < CYCLE_YEARS; i++) begin
      r = REST_W'(i);
      if (r < rest && is_leap(r)) begin
        acc = acc + REST_DAYS_W'(1);
      end
    end
    return acc;
  endfunction

  // Days in the months of a year that come before month m.
  function automatic logic [MDAY_W-1:0] days_before_month(input logic [MON_W-1:0] m);
    logic [MDAY_W-1:0] days;
    days = '0;
    unique case (m)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd62;
      4'd4:    days = 9'd93;
      4'd5:    days = 9'd124;
      4'd6:    days = 9'd155;
      4'd7:    days = 9'd186;
      4'd8:    days = 9'd216;
      4'd9:    days = 9'd246;
      4'd10:   days = 9'd276;
      4'd11:   days = 9'd306;
      4'd12:   days = 9'd336;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

FILE: rtl/calendar_day_distance.sv
// Calendar day distance: top level, a five stage pipeline over two date lanes.
// Depends on cdd_pkg.
//
// Takes a request holding two Solar Hijri dates and returns the absolute
// number of days between them, which date is the earlier, and a flag for an
// invalid date (month outside 1 to 12, or day outside the month's length in
// that year); with the flag set, count and order are both zero. Every request
// gives exactly one result. A new request is taken every cycle while the output
// does not stall: the stages are year / 33 by reciprocal multiply, quotient
// correction, cycle/year/month terms with the validity check, ordinal sum, and
// compare/subtract into the output register. The whole pipeline holds while a
// finished result waits for out_tready, so in_tready is low only in that case.
module calendar_day_distance (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // day_a[4:0], month_a[8:5], year_a[20:9], day_b[25:21], month_b[29:26],
  // year_b[41:30], zeros above
  input  logic [cdd_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // day_count[20:0], order[22:21], zero above
  output logic [cdd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // bad_date[0]
  output logic                            out_tuser
);

  localparam int YW = cdd_pkg::YEAR_WIDTH;
  localparam int DW = cdd_pkg::DAY_W;
  localparam int MW = cdd_pkg::MON_W;
  localparam int LANE_W = DW + MW + YW;

  // Advance every stage together; hold all of them while the output stalls.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Unpack the request into the two date lanes.
  logic [DW-1:0] in_day [2];
  logic [MW-1:0] in_mon [2];
  logic [YW-1:0] in_year[2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      in_day[l]  = in_tdata[l*LANE_W +: DW];
      in_mon[l]  = in_tdata[l*LANE_W + DW +: MW];
      in_year[l] = in_tdata[l*LANE_W + DW + MW +: YW];
    end
  end

  // Stage 1: year times reciprocal of 33.
  logic                       s1_vld_r;
  logic [cdd_pkg::PROD_W-1:0] s1_prod_r[2];
  logic [YW-1:0]              s1_year_r[2];
  logic [DW-1:0]              s1_day_r [2];
  logic [MW-1:0]              s1_mon_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        s1_prod_r[l] <= cdd_pkg::PROD_W'(in_year[l]) *
                        cdd_pkg::PROD_W'(cdd_pkg::REC_MULT);
        s1_year_r[l] <= in_year[l];
        s1_day_r[l]  <= in_day[l];
        s1_mon_r[l]  <= in_mon[l];
      end
    end
  end

  // Stage 2: correct the quotient estimate and form year mod 33.
  logic [cdd_pkg::QUOT_W-1:0] q_est   [2];
  logic [cdd_pkg::REST_W:0]   r_raw   [2];
  logic [cdd_pkg::QUOT_W-1:0] s2_quot_nxt[2];
  logic [cdd_pkg::REST_W-1:0] s2_rest_nxt[2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_est[l] = cdd_pkg::QUOT_W'(s1_prod_r[l] >> cdd_pkg::REC_SHIFT);
      r_raw[l] = (cdd_pkg::REST_W+1)'(s1_year_r[l] -
                 ({YW'(q_est[l]), 5'b0} + YW'(q_est[l])));
      if (r_raw[l] >= (cdd_pkg::REST_W+1)'(cdd_pkg::CYCLE_YEARS)) begin
        s2_quot_nxt[l] = q_est[l] + cdd_pkg::QUOT_W'(1);
        s2_rest_nxt[l] = cdd_pkg::REST_W'(r_raw[l] -
                         (cdd_pkg::REST_W+1)'(cdd_pkg::CYCLE_YEARS));
      end else begin
        s2_quot_nxt[l] = q_est[l];
        s2_rest_nxt[l] = cdd_pkg::REST_W'(r_raw[l]);
      end
    end
  end

  logic                       s2_vld_r;
  logic [cdd_pkg::QUOT_W-1:0] s2_quot_r[2];
  logic [cdd_pkg::REST_W-1:0] s2_rest_r[2];
  logic [DW-1:0]              s2_day_r [2];
  logic [MW-1:0]              s2_mon_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        s2_quot_r[l] <= s2_quot_nxt[l];
        s2_rest_r[l] <= s2_rest_nxt[l];
        s2_day_r[l]  <= s1_day_r[l];
        s2_mon_r[l]  <= s1_mon_r[l];
      end
    end
  end

  // Stage 3: validity check and the three ordinal terms.
  logic                            s3_ok_nxt[2];
  logic [4:0]                      mlen     [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (s2_mon_r[l] < MW'(7)) begin
        mlen[l] = 5'd31;
      end else if (s2_mon_r[l] < MW'(12)) begin
        mlen[l] = 5'd30;
      end else begin
        mlen[l] = cdd_pkg::is_leap(s2_rest_r[l]) ? 5'd30 : 5'd29;
      end
      s3_ok_nxt[l] = (s2_mon_r[l] >= MW'(1)) && (s2_mon_r[l] <= MW'(12)) &&
                     (s2_day_r[l] >= DW'(1)) && (s2_day_r[l] <= mlen[l]);
    end
  end

  logic                            s3_vld_r;
  logic                            s3_ok_r       [2];
  logic [cdd_pkg::ORD_W-1:0]       s3_cyc_r      [2];
  logic [cdd_pkg::REST_DAYS_W-1:0] s3_rest_days_r[2];
  logic [cdd_pkg::MDAY_W-1:0]      s3_mday_r     [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        s3_ok_r[l]        <= s3_ok_nxt[l];
        s3_cyc_r[l]       <= cdd_pkg::ORD_W'(s2_quot_r[l]) *
                             cdd_pkg::ORD_W'(cdd_pkg::CYCLE_DAYS);
        s3_rest_days_r[l] <= cdd_pkg::days_before_year(s2_rest_r[l]);
        s3_mday_r[l]      <= cdd_pkg::days_before_month(s2_mon_r[l]) +
                             cdd_pkg::MDAY_W'(s2_day_r[l]);
      end
    end
  end

  // Stage 4: sum the terms into a day ordinal per date.
  logic                      s4_vld_r;
  logic                      s4_bad_r;
  logic [cdd_pkg::ORD_W-1:0] s4_ord_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_bad_r <= !s3_ok_r[0] || !s3_ok_r[1];
      for (int l = 0; l < 2; l++) begin
        s4_ord_r[l] <= s3_cyc_r[l] + cdd_pkg::ORD_W'(s3_rest_days_r[l]) +
                       cdd_pkg::ORD_W'(s3_mday_r[l]);
      end
    end
  end

  // Stage 5: compare and subtract into the output register.
  logic [cdd_pkg::COUNT_W-1:0] out_count_nxt;
  cdd_pkg::order_t             out_order_nxt;
  always_comb begin
    priority if (s4_bad_r) begin
      out_count_nxt = '0;
      out_order_nxt = cdd_pkg::ORDER_EQUAL;
    end else if (s4_ord_r[0] > s4_ord_r[1]) begin
      out_count_nxt = cdd_pkg::COUNT_W'(s4_ord_r[0] - s4_ord_r[1]);
      out_order_nxt = cdd_pkg::ORDER_A_LATER;
    end else if (s4_ord_r[0] < s4_ord_r[1]) begin
      out_count_nxt = cdd_pkg::COUNT_W'(s4_ord_r[1] - s4_ord_r[0]);
      out_order_nxt = cdd_pkg::ORDER_A_EARLY;
    end else begin
      out_count_nxt = '0;
      out_order_nxt = cdd_pkg::ORDER_EQUAL;
    end
  end

  logic                        out_vld_r;
  logic [cdd_pkg::COUNT_W-1:0] out_count_r;
  cdd_pkg::order_t             out_order_r;
  logic                        out_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_count_r <= out_count_nxt;
      out_order_r <= out_order_nxt;
      out_bad_r   <= s4_bad_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(cdd_pkg::OUT_TDATA_W - cdd_pkg::OUT_FIELDS_W){1'b0}},
                       out_order_r, out_count_r};
  assign out_tuser  = out_bad_r;

  // A flagged date pair carries no distance and no order.
  a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_count_r == '0 && out_order_r == cdd_pkg::ORDER_EQUAL)
    else $error("bad date result carries a distance or order");

  // Equal order and a zero distance go together.
  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_order_r == cdd_pkg::ORDER_EQUAL) == (out_count_r == '0)))
    else $error("order and distance disagree");

  // Intake closes only while a finished result is held back.
  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("pipeline held without an output stall");

  // A request held in stage 4 during a stall keeps both of its day ordinals.
  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && !adv |=> s4_vld_r && $stable(s4_ord_r[0]) && $stable(s4_ord_r[1]))
    else $error("stage 4 lost its request during a stall");

endmodule
